// ----- rtl/dotq_pkg.sv -----
`default_nettype none
package dotq_pkg;

   localparam int DEPTH     = 16;
   localparam int TIME_BITS = 32;
   localparam int TAG_BITS  = 16;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_EXPIRED  = 2'd2;
   localparam logic [1:0] STATUS_NONE     = 2'd3;

   typedef struct packed {
      logic                 action;
      logic [31:0]          deadline_ms;
      logic [TAG_BITS-1:0]  task_tag;
      logic [31:0]          now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [TAG_BITS-1:0]  out_tag;
      logic [31:0]          out_deadline;
      logic                 last;
   } rsp_type;

   // One stored task held by a cell.
   typedef struct packed {
      logic                 valid;
      logic [TIME_BITS-1:0] deadline;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type          op;
      logic [TIME_BITS-1:0] deadline;
      logic [TAG_BITS-1:0]  tag;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/dotq_cell.sv -----
`default_nettype none
module dotq_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dotq_pkg::cell_ctrl_type ctrl,
   input  wire dotq_pkg::entry_type    prev_entry,
   input  wire logic                   prev_ahead,
   input  wire dotq_pkg::entry_type    next_entry,
   output dotq_pkg::entry_type         entry,
   output logic                        ahead
);

   dotq_pkg::entry_type entry_ff;
   dotq_pkg::entry_type entry_in;

   // This cell stays ahead of the new task when its deadline is strictly earlier.
   assign ahead = entry_ff.valid && (entry_ff.deadline < ctrl.deadline);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         dotq_pkg::CELL_INSERT: begin
            if (!ahead) begin
               if (prev_ahead) begin
                  entry_in.valid    = 1'b1;
                  entry_in.deadline = ctrl.deadline;
                  entry_in.tag      = ctrl.tag;
               end else begin
                  entry_in = prev_entry;
               end
            end
         end
         dotq_pkg::CELL_POP: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.deadline <= entry_in.deadline;
      entry_ff.tag      <= entry_in.tag;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/deadline_ordered_task_queue_core.sv -----
`default_nettype none
// Deadline-ordered task queue. The queue holds up to dotq_pkg::DEPTH tasks in a
// chain of cells, sorted by ascending deadline with the head in cell zero; a new
// task goes in front of every stored task whose deadline is at least as large, so
// the newest of equal deadlines comes first. An insert word always returns one
// result word: accepted, or full when the last cell is already occupied (the
// task is then dropped). A tick word pops every task whose deadline is strictly
// earlier than now_ms and returns one expired word per popped task, or a single
// none word; the last word of each group has last set. Ticks run at one popped
// task per cycle while the output is not stalled, a rate set by the chain
// shifting one cell toward the head per pop. The block works on one request
// word at a time and takes the next one at the earliest in the cycle in which
// its final result word leaves the output register. Times compare as unsigned
// values with no wrap-around handling.
module deadline_ordered_task_queue_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dotq_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dotq_pkg::rsp_type      rsp_word
);

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   state_type                        state_ff, state_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   dotq_pkg::rsp_type                rsp_ff, rsp_in;
   logic [dotq_pkg::TIME_BITS-1:0]   now_ff, now_in;

   dotq_pkg::cell_ctrl_type          ctrl;
   dotq_pkg::entry_type              cells [dotq_pkg::DEPTH];
   logic                             ahead [dotq_pkg::DEPTH];

   logic                             out_free;
   logic                             req_accept;
   logic                             full;
   logic [dotq_pkg::TIME_BITS-1:0]   cmp_time;
   logic                             head_exp;
   logic                             next_exp;

   // The output register frees up when it is empty or being taken this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // Cells fill from the head, so the queue is full once the tail cell holds a task.
   assign full = cells[dotq_pkg::DEPTH-1].valid;

   // During the first cycle of a tick the time comes straight from the request word.
   assign cmp_time = (state_ff == ST_IDLE) ? req_word.now_ms[dotq_pkg::TIME_BITS-1:0] : now_ff;
   assign head_exp = cells[0].valid && (cells[0].deadline < cmp_time);
   assign next_exp = cells[1].valid && (cells[1].deadline < cmp_time);

   genvar gi;
   generate
      for (gi = 0; gi < dotq_pkg::DEPTH; gi++) begin : g_cell
         dotq_pkg::entry_type prev_e;
         dotq_pkg::entry_type next_e;
         logic                prev_b;

         if (gi == 0) begin : g_head
            assign prev_e = '0;
            assign prev_b = 1'b1;
         end else begin : g_body
            assign prev_e = cells[gi-1];
            assign prev_b = ahead[gi-1];
         end

         if (gi == dotq_pkg::DEPTH-1) begin : g_tail
            assign next_e = '0;
         end else begin : g_inner
            assign next_e = cells[gi+1];
         end

         dotq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .prev_entry  (prev_e),
            .prev_ahead  (prev_b),
            .next_entry  (next_e),
            .entry       (cells[gi]),
            .ahead       (ahead[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      now_in        = now_ff;
      ctrl.op       = dotq_pkg::CELL_HOLD;
      ctrl.deadline = req_word.deadline_ms[dotq_pkg::TIME_BITS-1:0];
      ctrl.tag      = req_word.task_tag;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in        = 1'b1;
               rsp_in.out_tag      = '0;
               rsp_in.out_deadline = '0;
               rsp_in.last         = 1'b1;
               if (req_word.action == dotq_pkg::ACTION_INSERT) begin
                  if (full) begin
                     rsp_in.status = dotq_pkg::STATUS_FULL;
                  end else begin
                     rsp_in.status = dotq_pkg::STATUS_ACCEPTED;
                     ctrl.op       = dotq_pkg::CELL_INSERT;
                  end
               end else begin
                  now_in = req_word.now_ms[dotq_pkg::TIME_BITS-1:0];
                  if (head_exp) begin
                     rsp_in.status       = dotq_pkg::STATUS_EXPIRED;
                     rsp_in.out_tag      = cells[0].tag;
                     rsp_in.out_deadline = 32'(cells[0].deadline);
                     rsp_in.last         = !next_exp;
                     ctrl.op             = dotq_pkg::CELL_POP;
                     if (next_exp) begin
                        state_in = ST_POP;
                     end
                  end else begin
                     rsp_in.status = dotq_pkg::STATUS_NONE;
                  end
               end
            end
         end
         ST_POP: begin
            // The head is known to have expired; pop it once the output is free.
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = dotq_pkg::STATUS_EXPIRED;
               rsp_in.out_tag      = cells[0].tag;
               rsp_in.out_deadline = 32'(cells[0].deadline);
               rsp_in.last         = !next_exp;
               ctrl.op             = dotq_pkg::CELL_POP;
               if (!next_exp) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      now_ff <= now_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // The run stops here even if the block hangs. The worst correct run is
   // about 230 words, each waiting out a random idle gap to go in. A word can
   // cause up to 16 result words, each after a random stall. This limit
   // leaves a wide margin over such a run.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 203;
   localparam int TAIL_CYCLES  = 64;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   dotq_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   dotq_pkg::rsp_type rsp_word;

   deadline_ordered_task_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Request words waiting to be driven. The stimulus block fills this queue
   // at time zero, and the driver drains it.
   dotq_pkg::req_type request_backlog[$];
   // Result words that the shadow queue says the block still owes, oldest first.
   dotq_pkg::rsp_type predicted_responses[$];

   // Shadow copy of the task queue. Slot 0 is the head. Only slots below
   // shadow_count are ever read.
   logic [dotq_pkg::TIME_BITS-1:0] shadow_deadline[dotq_pkg::DEPTH];
   logic [dotq_pkg::TAG_BITS-1:0]  shadow_tag[dotq_pkg::DEPTH];
   int                             shadow_count = 0;

   int   words_planned  = 0;
   int   words_accepted = 0;
   int   error_count    = 0;
   int   cycle_count    = 0;
   logic req_fire       = 1'b0;
   logic rsp_fire       = 1'b0;
   int   req_idle       = 0;
   int   req_calm       = 0;
   int   rsp_idle       = 0;
   int   rsp_calm       = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one accepted request word to the shadow queue. It appends the
   // result words that the request word should produce.
   function automatic void advance_shadow_queue(input dotq_pkg::req_type w);
      logic [dotq_pkg::TIME_BITS-1:0] key;
      dotq_pkg::rsp_type              r;
      int                             pos;
      int                             i;
      r      = '0;
      r.last = 1'b1;
      pos    = 0;
      if (w.action == dotq_pkg::ACTION_INSERT) begin
         key = w.deadline_ms;
         if (shadow_count >= dotq_pkg::DEPTH) begin
            r.status = dotq_pkg::STATUS_FULL;
         end else begin
            // The new task goes in front of the first task due no earlier,
            // so the newest of equal deadlines ends up first.
            while (pos < shadow_count && shadow_deadline[pos] < key) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_deadline[i] = shadow_deadline[i-1];
               shadow_tag[i]      = shadow_tag[i-1];
            end
            shadow_deadline[pos] = key;
            shadow_tag[pos]      = w.task_tag;
            shadow_count++;
            r.status = dotq_pkg::STATUS_ACCEPTED;
         end
         predicted_responses.push_back(r);
      end else begin
         key = w.now_ms;
         // Only tasks strictly earlier than the current time expire.
         while (pos < shadow_count && shadow_deadline[pos] < key) pos++;
         if (pos == 0) begin
            r.status = dotq_pkg::STATUS_NONE;
            predicted_responses.push_back(r);
         end else begin
            for (i = 0; i < pos; i++) begin
               r.status       = dotq_pkg::STATUS_EXPIRED;
               r.out_tag      = shadow_tag[i];
               r.out_deadline = shadow_deadline[i];
               r.last         = (i == pos - 1);
               predicted_responses.push_back(r);
            end
            for (i = pos; i < shadow_count; i++) begin
               shadow_deadline[i-pos] = shadow_deadline[i];
               shadow_tag[i-pos]      = shadow_tag[i];
            end
            shadow_count -= pos;
         end
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // An insert word carries random junk in now_ms, which the block ignores.
   function automatic void add_insert(input logic [31:0] due,
                                      input logic [dotq_pkg::TAG_BITS-1:0] id);
      dotq_pkg::req_type w;
      w.action      = dotq_pkg::ACTION_INSERT;
      w.deadline_ms = due;
      w.task_tag    = id;
      w.now_ms      = $urandom;
      request_backlog.push_back(w);
   endfunction

   // A tick word carries random junk in the insert fields, which the block ignores.
   function automatic void add_tick(input logic [31:0] now);
      dotq_pkg::req_type w;
      w.action      = dotq_pkg::ACTION_TICK;
      w.deadline_ms = $urandom;
      w.task_tag    = 16'($urandom);
      w.now_ms      = now;
      request_backlog.push_back(w);
   endfunction

   // Idle cycles before the next word on either side. Now and then a calm
   // stretch of back-to-back words is chosen. Otherwise the count is drawn
   // uniformly at random.
   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // Request driver. It works on the falling edge. A word stays on the bus,
   // unchanged, until the monitor saw it accepted at the rising edge before.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_idle > 0) begin
            req_idle--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            req_word  <= request_backlog.pop_front();
            req_valid <= 1'b1;
            req_idle  = draw_idle(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver. It draws a fresh stall length after every accepted
   // result word. Stall does not look at rsp_valid, so stalls also land on
   // cycles where the block is still working.
   always @(negedge clock) begin
      if (rsp_fire) rsp_idle = draw_idle(rsp_calm);
      if (rsp_idle > 0) begin
         rsp_stall <= 1'b1;
         rsp_idle--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor. At each rising edge it checks the accepted result word against
   // the oldest prediction, then feeds the accepted request word to the shadow
   // queue. A result word never comes out in the same cycle as its request
   // word, so this order is safe.
   always @(posedge clock) begin
      dotq_pkg::rsp_type want;
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_responses.size() == 0) begin
            $error("unexpected result word: status %0d tag %0h deadline %0h last %0b",
                   rsp_word.status, rsp_word.out_tag, rsp_word.out_deadline, rsp_word.last);
            error_count++;
         end else begin
            want = predicted_responses.pop_front();
            compare_field("status", want.status, rsp_word.status);
            compare_field("out_tag", want.out_tag, rsp_word.out_tag);
            compare_field("out_deadline", want.out_deadline, rsp_word.out_deadline);
            compare_field("last", want.last, rsp_word.last);
         end
      end
      if (!reset && req_valid && !req_stall) begin
         advance_shadow_queue(req_word);
         words_accepted++;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d result words outstanding",
                  cycle_count, predicted_responses.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [31:0] clock_ms;
      logic [31:0] due;
      logic [31:0] last_due;
      logic [31:0] now;
      int          insert_pct;
      int          pick;
      int          n;

      // Directed part. The first word is a tick on an empty queue.
      add_tick(32'd0);
      // Next comes a new earliest task that must take the head, then an equal
      // deadline that must go in front of the older one, then time zero.
      add_insert(32'd100, 16'h0001);
      add_insert(32'd50, 16'h0002);
      add_insert(32'd100, 16'h0003);
      add_insert(32'd0, 16'h0000);
      // At now = 50 only the zero deadline is strictly earlier. At now = 101
      // the rest leave as 50, then tag 3, then tag 1.
      add_tick(32'd50);
      add_tick(32'd101);
      // Fill the queue with clustered deadlines, then try one more insert
      // while it is full.
      for (n = 0; n < dotq_pkg::DEPTH + 1; n++) begin
         add_insert($urandom_range(200, 215), 16'($urandom));
      end
      // This tick drains all DEPTH tasks in one burst.
      add_tick('1);
      // A task due at the largest time never expires: a tick at that same
      // time finds nothing strictly earlier. The task stays in the queue for
      // the rest of the run.
      add_insert('1, '1);
      add_tick('1);

      // Random part. It runs in episodes of 20 words with light, medium or
      // heavy insert traffic, so the queue both empties and fills up. Most
      // deadlines lie a little ahead of a running clock, so regular ticks
      // expire a few tasks at a time.
      clock_ms   = 32'd1000;
      last_due   = 32'd1000;
      insert_pct = 60;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 20 == 0) insert_pct = 30 + 30 * $urandom_range(0, 2);
         if ($urandom_range(0, 99) < insert_pct) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) due = clock_ms + $urandom_range(0, 300);
            else if (pick < 16) due = last_due;
            else if (pick < 19) due = $urandom;
            else due = '0;
            last_due = due;
            add_insert(due, 16'($urandom));
         end else begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
               clock_ms = clock_ms + $urandom_range(0, 150);
               now      = clock_ms;
            end else if (pick < 17) begin
               now = $urandom;
            end else if (pick < 19) begin
               now = '1;
            end else begin
               now = '0;
            end
            add_tick(now);
         end
      end
      words_planned = request_backlog.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request word to go in and every predicted result word
      // to come out. Then watch a while longer for stray result words.
      while (words_accepted != words_planned) @(negedge clock);
      while (predicted_responses.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && predicted_responses.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dotq_pkg.sv
rtl/dotq_cell.sv
rtl/deadline_ordered_task_queue_core.sv
dv/tb_top.sv
